### sv/pqe_pkg.sv
// Package for the polyline quad expander.
// Holds the controller states, command/status structs and fixed arithmetic widths.
// No dependencies.
package pqe_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int LW_W       = 16;
    localparam int COLOR_W    = 32;
    localparam int TEX_W      = 2;

    localparam int NORM_BITS  = 20;
    localparam int SQ_W       = 2 * NORM_BITS;
    localparam int RAD_SHIFT  = 16;
    localparam int RAD_W      = SQ_W + 1 + RAD_SHIFT;
    localparam int LEN_W      = 29;
    localparam int FRAC_SH    = 8;
    localparam int PROD_W     = LW_W + NORM_BITS;
    localparam int Q_W        = 17;
    localparam int NUM_W      = LEN_W + Q_W;
    localparam int OFS_W      = Q_W + 1;

    localparam int CFG_LINE_WIDTH = 0;
    localparam int CFG_COLOR      = 1;

    localparam logic [LW_W-1:0]    LINE_WIDTH_RESET = 16'd256;
    localparam logic [COLOR_W-1:0] COLOR_RESET      = 32'hFFFF_FFFF;

    localparam logic signed [TEX_W-1:0] TEX_POS = 2'sb01;
    localparam logic signed [TEX_W-1:0] TEX_NEG = 2'sb11;

    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 5'd29;
    localparam logic [CNT_W-1:0] DIV_STEPS  = 5'd17;
    localparam logic [CNT_W-1:0] VTX_COUNT  = 5'd12;
    localparam logic [CNT_W-1:0] SQ_START   = 5'd6;

    localparam int VIDX_W = 4;
    localparam logic [VIDX_W-1:0] SQ_FIRST_VIDX = 4'd6;
    localparam logic [VIDX_W-1:0] LAST_VIDX     = 4'd11;

    // Segment vertices: {use end point, subtract offset}.
    // Square vertices: {x side positive, y side positive}.
    localparam logic [1:0] VTX_CODE [12] = '{
        2'b00, 2'b01, 2'b10, 2'b01, 2'b11, 2'b10,
        2'b01, 2'b11, 2'b00, 2'b11, 2'b10, 2'b00
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_NORM,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } pqe_state_t;

    typedef struct packed {
        logic              in_ready;
        logic              norm_step;
        logic              square;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              sel_y;
        logic              mul;
        logic              div_init;
        logic              div_step;
        logic              store;
        logic              emit;
        logic              finish;
        logic [VIDX_W-1:0] vidx;
    } pqe_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic seg;
        logic norm_done;
        logic out_free;
    } pqe_stat_t;

endpackage

### sv/pqe_ifs.sv
// Channel interfaces for the polyline quad expander: input points and output vertices.
// Depends on nothing; payload widths follow COORD_WIDTH.
interface pqe_point_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          first_point;

    modport source (output valid, point_x, point_y, first_point, input ready);
    modport sink   (input valid, point_x, point_y, first_point, output ready);
endinterface

interface pqe_vert_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic                          prim_kind;
    logic signed [COORD_WIDTH-1:0] vert_x;
    logic signed [COORD_WIDTH-1:0] vert_y;
    logic signed [1:0]             tex_u;
    logic signed [1:0]             tex_v;
    logic [31:0]                   vert_color;
    logic                          last_vertex;

    modport source (output valid, prim_kind, vert_x, vert_y, tex_u, tex_v, vert_color,
                    last_vertex, input ready);
    modport sink   (input valid, prim_kind, vert_x, vert_y, tex_u, tex_v, vert_color,
                    last_vertex, output ready);
endinterface

### sv/pqe_ctrl.sv
// Controller state machine for the polyline quad expander.
// Sequences normalize, square root, two divides and vertex emission; uses pqe_pkg.
module pqe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  pqe_pkg::pqe_stat_t stat,
    output pqe_pkg::pqe_cmd_t  cmd
);
    import pqe_pkg::*;

    pqe_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel_y  = sel_reg;
        cmd.vidx   = cnt_reg[VIDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.seg)
                    state_next = ST_NORM;
                else
                begin
                    cnt_next   = SQ_START;
                    state_next = ST_EMIT;
                end
            end
            ST_NORM:
            begin
                if (stat.norm_done)
                    state_next = ST_SQUARE;
                else
                    cmd.norm_step = 1'b1;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_ROOT_INIT;
            end
            ST_ROOT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_STEPS - 1'b1)
                begin
                    sel_next   = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_STEPS - 1'b1)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (sel_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (cnt_reg == VTX_COUNT - 1'b1)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                        cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/pqe_dpath.sv
// Datapath for the polyline quad expander: config registers, offset arithmetic
// (normalize, bit-serial isqrt, restoring divide) and the vertex output register. Uses pqe_pkg.
module pqe_dpath #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pqe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pqe_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  pqe_pkg::pqe_cmd_t               cmd,
    output pqe_pkg::pqe_stat_t              stat,
    pqe_point_if.sink                       points,
    pqe_vert_if.source                      verts
);
    import pqe_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int MAG_W  = (DIFF_W > NORM_BITS) ? DIFF_W : NORM_BITS + 1;
    localparam int EXT_W  = ((COORD_WIDTH > OFS_W) ? COORD_WIDTH : OFS_W) + 2;
    localparam logic signed [EXT_W-1:0] CMAX = EXT_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [EXT_W-1:0] CMIN = ~CMAX;

    logic [LW_W-1:0]    width_reg;
    logic [COLOR_W-1:0] color_reg;
    logic               have_prev_reg;
    logic               out_valid_reg;

    logic signed [COORD_WIDTH-1:0] cur_x_reg, cur_y_reg, prev_x_reg, prev_y_reg;
    logic                          seg_reg, dxneg_reg, dyneg_reg;
    logic [MAG_W-1:0]              adx_reg, ady_reg;
    logic [SQ_W-1:0]               sqx_reg, sqy_reg;
    logic [RAD_W-1:0]              rad_reg, root_reg, rbit_reg;
    logic [PROD_W-1:0]             prod_reg;
    logic [NUM_W-1:0]              num_reg, dsh_reg;
    logic [Q_W-1:0]                q_reg;
    logic signed [OFS_W-1:0]       rx_reg, ry_reg;

    logic                          out_kind_reg, out_last_reg;
    logic signed [COORD_WIDTH-1:0] out_x_reg, out_y_reg;
    logic signed [TEX_W-1:0]       out_u_reg, out_v_reg;
    logic [COLOR_W-1:0]            out_color_reg;

    logic                          accept;
    logic signed [DIFF_W-1:0]      dx, dy;
    logic [MAG_W-1:0]              adx_in, ady_in;
    logic [NORM_BITS-1:0]          adx_n, ady_n, mul_src;
    logic [RAD_W:0]                trial;
    logic [LEN_W-1:0]              len;
    logic [Q_W-1:0]                mag;
    logic signed [OFS_W-1:0]       mag_s;
    logic [1:0]                    code;
    logic                          is_sq;
    logic [LW_W-1:0]               half_w;
    logic signed [EXT_W-1:0]       he, rxe, rye, base_x, base_y, off_x, off_y;
    logic signed [EXT_W-1:0]       sum_x, sum_y;
    logic signed [TEX_W-1:0]       tex_u, tex_v;

    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] c;
        begin
            c = v;
            if (v > CMAX)
                c = CMAX;
            else if (v < CMIN)
                c = CMIN;
            return c[COORD_WIDTH-1:0];
        end
    endfunction

    assign accept        = points.valid & points.ready;
    assign points.ready  = cmd.in_ready;

    assign stat.in_valid  = points.valid;
    assign stat.seg       = seg_reg;
    assign stat.norm_done = (adx_reg[MAG_W-1:NORM_BITS] == '0) &&
                            (ady_reg[MAG_W-1:NORM_BITS] == '0);
    assign stat.out_free  = !out_valid_reg || verts.ready;

    always_comb
    begin
        dx     = DIFF_W'(points.point_x) - DIFF_W'(prev_x_reg);
        dy     = DIFF_W'(points.point_y) - DIFF_W'(prev_y_reg);
        adx_in = dx[DIFF_W-1] ? MAG_W'($unsigned(-dx)) : MAG_W'($unsigned(dx));
        ady_in = dy[DIFF_W-1] ? MAG_W'($unsigned(-dy)) : MAG_W'($unsigned(dy));
    end

    assign adx_n   = adx_reg[NORM_BITS-1:0];
    assign ady_n   = ady_reg[NORM_BITS-1:0];
    assign mul_src = cmd.sel_y ? adx_n : ady_n;
    assign trial   = {1'b0, root_reg} + {1'b0, rbit_reg};
    assign len     = root_reg[LEN_W-1:0];
    assign mag     = (len == '0) ? '0 : q_reg;
    assign mag_s   = $signed({1'b0, mag});

    // Vertex generation
    always_comb
    begin
        code   = VTX_CODE[cmd.vidx];
        is_sq  = (cmd.vidx >= SQ_FIRST_VIDX);
        half_w = LW_W'(({1'b0, width_reg} + 17'd1) >> 1);
        he     = $signed(EXT_W'(half_w));
        rxe    = EXT_W'(rx_reg);
        rye    = EXT_W'(ry_reg);
        if (is_sq)
        begin
            base_x = EXT_W'(cur_x_reg);
            base_y = EXT_W'(cur_y_reg);
            off_x  = code[1] ? he : -he;
            off_y  = code[0] ? he : -he;
            tex_u  = code[1] ? TEX_POS : TEX_NEG;
            tex_v  = code[0] ? TEX_NEG : TEX_POS;
        end
        else
        begin
            base_x = code[1] ? EXT_W'(cur_x_reg) : EXT_W'(prev_x_reg);
            base_y = code[1] ? EXT_W'(cur_y_reg) : EXT_W'(prev_y_reg);
            off_x  = code[0] ? -rxe : rxe;
            off_y  = code[0] ? -rye : rye;
            tex_u  = $signed({1'b0, code[0]});
            tex_v  = $signed({1'b0, code[1]});
        end
        sum_x = base_x + off_x;
        sum_y = base_y + off_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= LINE_WIDTH_RESET;
            color_reg     <= COLOR_RESET;
            have_prev_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (int'(cfg_index))
                    CFG_LINE_WIDTH: width_reg <= cfg_data[LW_W-1:0];
                    CFG_COLOR:      color_reg <= cfg_data[COLOR_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.finish)
                have_prev_reg <= 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (verts.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_x_reg <= points.point_x;
            cur_y_reg <= points.point_y;
            seg_reg   <= !points.first_point && have_prev_reg;
            dxneg_reg <= dx[DIFF_W-1];
            dyneg_reg <= dy[DIFF_W-1];
            adx_reg   <= adx_in;
            ady_reg   <= ady_in;
        end
        else if (cmd.norm_step)
        begin
            adx_reg <= adx_reg >> 1;
            ady_reg <= ady_reg >> 1;
        end
        if (cmd.square)
        begin
            sqx_reg <= SQ_W'(adx_n) * SQ_W'(adx_n);
            sqy_reg <= SQ_W'(ady_n) * SQ_W'(ady_n);
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= (RAD_W'(sqx_reg) + RAD_W'(sqy_reg)) << RAD_SHIFT;
            root_reg <= '0;
            rbit_reg <= RAD_W'(1) << (RAD_W - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if ({1'b0, rad_reg} >= trial)
            begin
                rad_reg  <= rad_reg - trial[RAD_W-1:0];
                root_reg <= (root_reg >> 1) + rbit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            rbit_reg <= rbit_reg >> 2;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(width_reg) * PROD_W'(mul_src);
        if (cmd.div_init)
        begin
            num_reg <= (NUM_W'(prod_reg) << FRAC_SH) + NUM_W'(len);
            dsh_reg <= NUM_W'(len) << Q_W;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (num_reg >= dsh_reg)
            begin
                num_reg <= num_reg - dsh_reg;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
                q_reg <= {q_reg[Q_W-2:0], 1'b0};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.store)
        begin
            if (cmd.sel_y)
                ry_reg <= dxneg_reg ? mag_s : -mag_s;
            else
                rx_reg <= dyneg_reg ? -mag_s : mag_s;
        end
        if (cmd.finish)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.emit)
        begin
            out_kind_reg  <= is_sq;
            out_x_reg     <= sat(sum_x);
            out_y_reg     <= sat(sum_y);
            out_u_reg     <= tex_u;
            out_v_reg     <= tex_v;
            out_color_reg <= color_reg;
            out_last_reg  <= (cmd.vidx == LAST_VIDX);
        end
    end

    assign verts.valid       = out_valid_reg;
    assign verts.prim_kind   = out_kind_reg;
    assign verts.vert_x      = out_x_reg;
    assign verts.vert_y      = out_y_reg;
    assign verts.tex_u       = out_u_reg;
    assign verts.tex_v       = out_v_reg;
    assign verts.vert_color  = out_color_reg;
    assign verts.last_vertex = out_last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || verts.ready))
        else $error("vertex loaded over a pending transaction");

    a_prev_set: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(have_prev_reg) |-> $past(cmd.finish))
        else $error("previous point marked without finishing a point");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (cmd.emit && cmd.vidx == LAST_VIDX))
        else $error("point finished away from its last vertex");

endmodule

### sv/polyline_quad_expander.sv
// Polyline quad expander top level: thick polyline stroke to triangle-list vertices.
// Instantiates pqe_ctrl and pqe_dpath; uses pqe_pkg and the interfaces in pqe_ifs.sv.
//
//   channel   dir   payload                                             handshake
//   points    in    point_x, point_y, first_point                       valid/ready
//   verts     out   prim_kind, vert_x, vert_y, tex_u, tex_v,            valid/ready
//                   vert_color, last_vertex
//   cfg       in    cfg_index, cfg_data                                 cfg_we
//
// A point without a segment passes through accept, decide and 6 vertices.
// A point with a segment passes through s normalize shifts (0..COORD_WIDTH-20), the square,
// the bit-serial square root, two passes of the shared restoring divider and 12 vertices.
// The vertex register is independent: a new point is taken while the last vertex waits.
// Output stalls hold vertex emission; no reset pass, the block is ready right after reset.
module polyline_quad_expander #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pqe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pqe_pkg::CFG_DATA_W-1:0] cfg_data,
    pqe_point_if.sink                      points,
    pqe_vert_if.source                     verts
);
    import pqe_pkg::*;

    pqe_cmd_t  cmd;
    pqe_stat_t stat;

    pqe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    pqe_dpath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .points    (points),
        .verts     (verts)
    );

endmodule

### dv/tb_top.sv
// Testbench for polyline_quad_expander: random and directed polyline points, vertex checking.
// Depends on pqe_pkg, sv/pqe_ifs.sv and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
    import pqe_pkg::*;

    typedef struct {
        logic              kind;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [1:0] u;
        logic signed [1:0] v;
        logic [31:0]       color;
        logic              last;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pqe_point_if #(24) pts ();
    pqe_vert_if #(24) vts ();

    polyline_quad_expander #(.COORD_WIDTH(24)) i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .points(pts.sink), .verts(vts.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    vertex_t expected_verts[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    longint cycle_count = 0;
    int points_sent = 0;
    int verts_seen = 0;

    logic [15:0] m_width = LINE_WIDTH_RESET;
    logic [31:0] m_color = COLOR_RESET;
    longint m_px = 0, m_py = 0;
    bit m_have = 0;

    initial
    begin
        pts.valid = 1'b0;
        pts.point_x = '0;
        pts.point_y = '0;
        pts.first_point = 1'b0;
        vts.ready = 1'b0;
    end

    function automatic longint sat24(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void push_vert(logic k, longint x, longint y, int u, int v, bit last);
        vertex_t e;
        e.kind = k;
        e.x = sat24(x);
        e.y = sat24(y);
        e.u = u;
        e.v = v;
        e.color = m_color;
        e.last = last;
        expected_verts.push_back(e);
    endfunction

    function automatic void predict_vertices(logic signed [23:0] px, logic signed [23:0] py,
                                             logic first);
        longint bx = px, by = py;
        longint w = m_width;
        longint h = (w + 1) >>> 1;
        longint dx, dy, rx, ry;
        longint unsigned adx, ady, len, mx, my;
        if (!first && m_have)
        begin
            dx = bx - m_px;
            dy = by - m_py;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            rx = 0;
            ry = 0;
            while (adx >= (64'd1 << 20) || ady >= (64'd1 << 20))
            begin
                adx >>= 1;
                ady >>= 1;
            end
            len = root64((adx * adx + ady * ady) << 16);
            if (len != 0)
            begin
                mx = (w * ady * 256 + len) / (2 * len);
                my = (w * adx * 256 + len) / (2 * len);
                rx = dy < 0 ? -longint'(mx) : longint'(mx);
                ry = dx < 0 ? longint'(my) : -longint'(my);
            end
            push_vert(0, m_px + rx, m_py + ry, 0, 0, 0);
            push_vert(0, m_px - rx, m_py - ry, 1, 0, 0);
            push_vert(0, bx + rx, by + ry, 0, 1, 0);
            push_vert(0, m_px - rx, m_py - ry, 1, 0, 0);
            push_vert(0, bx - rx, by - ry, 1, 1, 0);
            push_vert(0, bx + rx, by + ry, 0, 1, 0);
        end
        push_vert(1, bx - h, by + h, -1, -1, 0);
        push_vert(1, bx + h, by + h, 1, -1, 0);
        push_vert(1, bx - h, by - h, -1, 1, 0);
        push_vert(1, bx + h, by + h, 1, -1, 0);
        push_vert(1, bx + h, by - h, 1, 1, 0);
        push_vert(1, bx - h, by - h, -1, 1, 1);
        m_px = bx;
        m_py = by;
        m_have = 1;
    endfunction

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random ready, optional long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                vts.ready <= 1'b0;
            end
            else
                vts.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // vertex checker
    always @(posedge clk)
    begin
        vertex_t e;
        if (rst_n && vts.valid && vts.ready)
        begin
            verts_seen++;
            if (expected_verts.size() == 0)
            begin
                $error("unexpected vertex transaction");
                errors++;
            end
            else
            begin
                e = expected_verts.pop_front();
                if (vts.prim_kind !== e.kind)
                begin
                    $error("prim_kind exp %0d got %0d", e.kind, vts.prim_kind); errors++;
                end
                if (vts.vert_x !== e.x)
                begin
                    $error("vert_x exp %0d got %0d", e.x, vts.vert_x); errors++;
                end
                if (vts.vert_y !== e.y)
                begin
                    $error("vert_y exp %0d got %0d", e.y, vts.vert_y); errors++;
                end
                if (vts.tex_u !== e.u)
                begin
                    $error("tex_u exp %0d got %0d", e.u, vts.tex_u); errors++;
                end
                if (vts.tex_v !== e.v)
                begin
                    $error("tex_v exp %0d got %0d", e.v, vts.tex_v); errors++;
                end
                if (vts.vert_color !== e.color)
                begin
                    $error("vert_color exp %h got %h", e.color, vts.vert_color); errors++;
                end
                if (vts.last_vertex !== e.last)
                begin
                    $error("last_vertex exp %0d got %0d", e.last, vts.last_vertex); errors++;
                end
            end
        end
    end

    // valid stays up after acceptance; the next call replaces or drops it, a drain drops it
    task automatic send_point(logic signed [23:0] x, logic signed [23:0] y, logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pts.valid <= 1'b0;
            @(posedge clk);
        end
        pts.valid <= 1'b1;
        pts.point_x <= x;
        pts.point_y <= y;
        pts.first_point <= first;
        @(posedge clk);
        while (!pts.ready)
            @(posedge clk);
        predict_vertices(x, y, first);
        points_sent++;
    endtask

    task automatic drain_vertices();
        pts.valid <= 1'b0;
        while (expected_verts.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        drain_vertices();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LINE_WIDTH) m_width = val[15:0];
        else if (idx == CFG_COLOR) m_color = val;
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(3))
            0: return 24'($urandom);
            1: return $signed(24'($urandom_range(4095))) - 2048;
            2: return $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
            default: return $signed(24'($urandom_range(131071))) - 65536;
        endcase
    endfunction

    task automatic test_directed();
        send_point(0, 0, 0);
        send_point(0, 0, 0);
        send_point(24'sh7FFFFF, 24'sh7FFFFF, 0);
        send_point(-24'sh800000, -24'sh800000, 0);
        send_point(-24'sh800000, 24'sh7FFFFF, 0);
        send_point(1000, 0, 1);
        send_point(1000, 2560, 0);
        send_point(-3000, 2560, 0);
        send_point(-3000, -700, 0);
        send_point(24'h555555, 24'shAAAAAA, 0);
        write_reg(CFG_LINE_WIDTH, 0);
        write_reg(CFG_COLOR, 0);
        send_point(500, 500, 0);
        send_point(900, 100, 0);
        write_reg(CFG_LINE_WIDTH, 16'hFFFF);
        write_reg(CFG_COLOR, 32'h12345678);
        send_point(24'sh7FFF00, 0, 0);
        send_point(-24'sh7FFF00, 5, 0);
        send_point(3, 3, 1);
        send_point(4, 3, 0);
        send_point(4, 4, 0);
        drain_vertices();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(49) == 0)
                write_reg($urandom_range(1), $urandom);
            send_point(rand_coord(), rand_coord(), $urandom_range(9) == 0);
        end
        drain_vertices();
    endtask

    task automatic test_backpressure();
        hold_cycles = 600;
        for (int i = 0; i < 20; i++)
            send_point(rand_coord(), rand_coord(), 0);
        drain_vertices();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 33; recv_idle_pct = 83;
        test_random(140);
        send_idle_pct = 83; recv_idle_pct = 33;
        test_random(140);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(140);
        test_backpressure();
        drain_vertices();
        $display("Covered %0d points and %0d vertices over width/color settings,", points_sent,
                 verts_seen);
        $display("segment, square, saturation and backpressure cases.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
